/* rtl/core/ppsc_pkg.sv */
// Shared types, prefix tables and codes for the path prefix severity classifier.
`default_nettype none

package ppsc_pkg;

   localparam int unsigned RULE_COUNT      = 9;
   localparam int unsigned PREFIX_MAX      = 17;
   localparam int unsigned WINDOW_BYTES    = 5;
   localparam int unsigned SSH_SEARCH_SPAN = 128;
   localparam int unsigned RULE_HOME       = 4;

   localparam logic [7:0]  CHAR_SLASH = 8'h2F;
   localparam logic [7:0]  CHAR_DOT   = 8'h2E;
   localparam logic [7:0]  CHAR_S     = 8'h73;
   localparam logic [7:0]  CHAR_H     = 8'h68;

   localparam logic [31:0] WRITE_LIKE_MASK = 32'h0000_0243;

   localparam logic [2:0]  LEVEL_MEDIUM   = 3'd2;
   localparam logic [2:0]  LEVEL_HIGH     = 3'd3;
   localparam logic [2:0]  LEVEL_CRITICAL = 3'd4;

   // Prefix characters, zero padded to the longest rule.
   localparam logic [7:0] PREFIX_TEXT [RULE_COUNT][PREFIX_MAX] = '{
      '{8'h2F, 8'h65, 8'h74, 8'h63, 8'h2F, 8'h73, 8'h68, 8'h61, 8'h64, 8'h6F, 8'h77,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h2F, 8'h65, 8'h74, 8'h63, 8'h2F, 8'h73, 8'h75, 8'h64, 8'h6F, 8'h65, 8'h72,
        8'h73, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h2F, 8'h65, 8'h74, 8'h63, 8'h2F, 8'h70, 8'h61, 8'h73, 8'h73, 8'h77, 8'h64,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h2F, 8'h72, 8'h6F, 8'h6F, 8'h74, 8'h2F, 8'h2E, 8'h73, 8'h73, 8'h68, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h2F, 8'h68, 8'h6F, 8'h6D, 8'h65, 8'h2F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h2F, 8'h70, 8'h72, 8'h6F, 8'h63, 8'h2F, 8'h6B, 8'h63, 8'h6F, 8'h72, 8'h65,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h2F, 8'h70, 8'h72, 8'h6F, 8'h63, 8'h2F, 8'h73, 8'h79, 8'h73, 8'h2F, 8'h6B,
        8'h65, 8'h72, 8'h6E, 8'h65, 8'h6C, 8'h00},
      '{8'h2F, 8'h76, 8'h61, 8'h72, 8'h2F, 8'h6C, 8'h6F, 8'h67, 8'h2F, 8'h61, 8'h75,
        8'h74, 8'h68, 8'h2E, 8'h6C, 8'h6F, 8'h67},
      '{8'h2F, 8'h76, 8'h61, 8'h72, 8'h2F, 8'h6C, 8'h6F, 8'h67, 8'h2F, 8'h73, 8'h65,
        8'h63, 8'h75, 8'h72, 8'h65, 8'h00, 8'h00}
   };

   localparam logic [7:0] PREFIX_LEN [RULE_COUNT] = '{
      8'd11, 8'd12, 8'd11, 8'd10, 8'd6, 8'd11, 8'd16, 8'd17, 8'd15
   };

   localparam logic [2:0] RULE_SEVERITY [RULE_COUNT] = '{
      LEVEL_CRITICAL, LEVEL_CRITICAL, LEVEL_MEDIUM, LEVEL_CRITICAL, LEVEL_HIGH,
      LEVEL_CRITICAL, LEVEL_HIGH, LEVEL_MEDIUM, LEVEL_MEDIUM
   };

   // Handshake control seen by every cell.
   typedef struct packed {
      logic accept;
      logic last;
   } ctrl_type;

   // Byte under test and its position in the path.
   typedef struct packed {
      logic [7:0] data;
      logic [7:0] pos;
   } step_type;

   // Priority chain between rule cells: first matching rule wins.
   typedef struct packed {
      logic       hit;
      logic [3:0] index;
   } hit_type;

endpackage

`default_nettype wire

/* rtl/core/ppsc_channels.sv */
// Valid/ready channel interfaces for request, response and register write.
`default_nettype none

interface ppsc_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  path_byte;
   logic        last_byte;
   logic [31:0] process_id;
   logic [31:0] open_flags;

   modport source (output valid, output path_byte, output last_byte,
                   output process_id, output open_flags, input ready);
   modport sink   (input valid, input path_byte, input last_byte,
                   input process_id, input open_flags, output ready);
endinterface

interface ppsc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  severity;
   logic [3:0]  rule_index;
   logic        raised_by_write;

   modport source (output valid, output severity, output rule_index,
                   output raised_by_write, input ready);
   modport sink   (input valid, input severity, input rule_index,
                   input raised_by_write, output ready);
endinterface

interface ppsc_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] target_process;

   modport source (output valid, output target_process, input ready);
   modport sink   (input valid, input target_process, output ready);
endinterface

`default_nettype wire

/* rtl/core/ppsc_byte_cell.sv */
// One byte stage of the recent-byte window; shifts toward its neighbor on each accepted byte, clears on the last.
`default_nettype none

module ppsc_byte_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ppsc_pkg::ctrl_type ctrl,
   input  wire logic [7:0]         byte_in,
   output logic [7:0]              byte_out
);
   import ppsc_pkg::*;

   logic [7:0] byte_ff;
   logic [7:0] byte_in_mux;

   always_comb begin
      byte_in_mux = byte_ff;
      if (ctrl.accept) begin
         byte_in_mux = ctrl.last ? 8'h00 : byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= 8'h00;
      end else begin
         byte_ff <= byte_in_mux;
      end
   end

   assign byte_out = byte_ff;

endmodule

`default_nettype wire

/* rtl/core/ppsc_rule_cell.sv */
// One prefix rule: alive bit, per-byte compare and a link in the priority chain.
`default_nettype none

module ppsc_rule_cell #(
   parameter int unsigned RULE = 0
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ppsc_pkg::ctrl_type ctrl,
   input  wire ppsc_pkg::step_type step,
   input  wire logic               qualify,
   input  wire ppsc_pkg::hit_type  chain_in,
   output ppsc_pkg::hit_type       chain_out
);
   import ppsc_pkg::*;

   localparam logic [7:0] LEN = PREFIX_LEN[RULE];

   logic       alive_ff;
   logic       alive_in;
   logic [4:0] char_idx;
   logic       mismatch;
   logic       match;

   always_comb begin
      char_idx = (step.pos < 8'(PREFIX_MAX)) ? step.pos[4:0] : 5'd0;
      mismatch = (step.pos < LEN) && (PREFIX_TEXT[RULE][char_idx] != step.data);
      alive_in = alive_ff && !mismatch;
      match    = alive_in && (step.pos >= LEN - 8'd1) && qualify;
   end

   // Pass an earlier hit through; otherwise claim the slot on a match.
   always_comb begin
      chain_out = chain_in;
      if (!chain_in.hit && match) begin
         chain_out.hit   = 1'b1;
         chain_out.index = 4'(RULE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alive_ff <= 1'b1;
      end else if (ctrl.accept) begin
         alive_ff <= ctrl.last ? 1'b1 : alive_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/path_prefix_severity_classifier.sv */
// Top level of the path prefix severity classifier.
//
// Requests carry one path character each on req_chan; last_byte marks the
// final one, and process_id and open_flags are sampled with it. Each character
// is compared by a row of nine rule cells and shifted into a row of five
// byte cells that spot a "/.ssh" segment. On the final character the
// priority chain through the rule cells picks the first matching rule, and a
// response (severity, rule_index, raised_by_write) is loaded into the output
// register and shown on rsp_chan in the cycle after that request. Unmatched
// paths and filtered processes give no response.
// Throughput is one request per cycle; req_chan.ready drops only while a
// response sits in the output register and rsp_chan.ready is low, so a stalled
// receiver stalls the path stream and nothing is lost.
// csr_chan writes the process filter (zero passes every process); it is
// always ready and should be written only when the block is idle.
// Synchronous reset clears the path state and the filter; no clearing pass.
`default_nettype none

module path_prefix_severity_classifier (
   input wire logic   clock,
   input wire logic   reset,
   ppsc_req_if.sink   req_chan,
   ppsc_rsp_if.source rsp_chan,
   ppsc_csr_if.sink   csr_chan
);
   import ppsc_pkg::*;

   ctrl_type   ctrl;
   step_type   step;
   logic [7:0] pos_ff;
   logic [7:0] pos_in;
   logic       seen_ff;
   logic       seen_in;
   logic       seen_now;
   logic       seg_slash;
   logic       seg_end;
   logic       pat_now;
   logic       pat_new;
   logic [31:0] target_ff;
   logic       skip;
   logic       emit;
   logic       write_like;
   logic [2:0] sev_base;

   logic [7:0] win [WINDOW_BYTES];
   hit_type    chain [RULE_COUNT + 1];

   logic       rsp_valid_ff;
   logic [2:0] severity_ff;
   logic [3:0] rule_ff;
   logic       raised_ff;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign ctrl.accept = req_chan.valid && req_chan.ready;
   assign ctrl.last   = req_chan.last_byte;
   assign step.data   = req_chan.path_byte;
   assign step.pos    = pos_ff;

   // Window of recent bytes: cell 0 holds the newest.
   for (genvar k = 0; k < WINDOW_BYTES; k++) begin : g_win
      if (k == 0) begin : g_head
         ppsc_byte_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctrl     (ctrl),
            .byte_in  (req_chan.path_byte),
            .byte_out (win[k])
         );
      end else begin : g_tail
         ppsc_byte_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctrl     (ctrl),
            .byte_in  (win[k-1]),
            .byte_out (win[k])
         );
      end
   end

   always_comb begin
      pat_now = (win[4] == CHAR_SLASH) && (win[3] == CHAR_DOT) && (win[2] == CHAR_S)
             && (win[1] == CHAR_S) && (win[0] == CHAR_H);
      pat_new = (win[3] == CHAR_SLASH) && (win[2] == CHAR_DOT) && (win[1] == CHAR_S)
             && (win[0] == CHAR_S) && (req_chan.path_byte == CHAR_H);
      seg_slash = (req_chan.path_byte == CHAR_SLASH) && pat_now && (pos_ff >= 8'd5)
               && ({1'b0, pos_ff} < 9'(SSH_SEARCH_SPAN + 5));
      seg_end = req_chan.last_byte && pat_new && (pos_ff >= 8'd4)
             && ({1'b0, pos_ff} < 9'(SSH_SEARCH_SPAN + 4));
      seen_now = seen_ff || seg_slash || seg_end;
      seen_in  = seen_ff;
      pos_in   = pos_ff;
      if (ctrl.accept) begin
         seen_in = req_chan.last_byte ? 1'b0 : (seen_ff || seg_slash);
         if (req_chan.last_byte) begin
            pos_in = 8'd0;
         end else if (pos_ff != 8'hFF) begin
            pos_in = pos_ff + 8'd1;
         end
      end
   end

   assign chain[0] = '{hit: 1'b0, index: 4'd0};

   for (genvar r = 0; r < RULE_COUNT; r++) begin : g_rule
      ppsc_rule_cell #(
         .RULE (r)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .step      (step),
         .qualify   ((r == RULE_HOME) ? seen_now : 1'b1),
         .chain_in  (chain[r]),
         .chain_out (chain[r+1])
      );
   end

   always_comb begin
      skip       = (target_ff != 32'd0) && (req_chan.process_id != target_ff);
      emit       = ctrl.accept && req_chan.last_byte && chain[RULE_COUNT].hit && !skip;
      write_like = (req_chan.open_flags & WRITE_LIKE_MASK) != 32'd0;
      sev_base   = RULE_SEVERITY[chain[RULE_COUNT].index];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= 8'd0;
         seen_ff      <= 1'b0;
         target_ff    <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         seen_ff <= seen_in;
         if (csr_chan.valid) begin
            target_ff <= csr_chan.target_process;
         end
         if (req_chan.ready) begin
            rsp_valid_ff <= emit;
         end
      end
   end

   // Load the response payload only with a new result; hold it while stalled.
   always_ff @(posedge clock) begin
      if (emit) begin
         rule_ff <= chain[RULE_COUNT].index;
         if (write_like && (sev_base != LEVEL_CRITICAL)) begin
            severity_ff <= LEVEL_CRITICAL;
            raised_ff   <= 1'b1;
         end else begin
            severity_ff <= sev_base;
            raised_ff   <= 1'b0;
         end
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.severity        = severity_ff;
   assign rsp_chan.rule_index      = rule_ff;
   assign rsp_chan.raised_by_write = raised_ff;

endmodule

`default_nettype wire

/* rtl/core/ppsc_checker.sv */
// Port-level checks for the classifier and the bind that attaches them.
`default_nettype none

module ppsc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       req_last,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [2:0] rsp_severity,
   input wire logic [3:0] rsp_rule_index,
   input wire logic       rsp_raised
);
   import ppsc_pkg::*;

   // A stalled response holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_severity)
         && $stable(rsp_rule_index) && $stable(rsp_raised))
      else $error("stalled response changed");

   // A fresh response follows an accepted final request.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(rsp_valid && !rsp_ready)
         |-> $past(req_valid && req_ready && req_last))
      else $error("response without a final request");

   // With the output slot empty, requests are always taken.
   a_req_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_rule_index <= 4'(RULE_COUNT - 1))
         && (rsp_severity == LEVEL_MEDIUM || rsp_severity == LEVEL_HIGH
             || rsp_severity == LEVEL_CRITICAL))
      else $error("response fields out of range");

   a_raised_critical: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_raised |-> rsp_severity == LEVEL_CRITICAL)
      else $error("raised response not critical");

endmodule

bind path_prefix_severity_classifier ppsc_checker u_ppsc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .req_last       (req_chan.last_byte),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_severity   (rsp_chan.severity),
   .rsp_rule_index (rsp_chan.rule_index),
   .rsp_raised     (rsp_chan.raised_by_write)
);

`default_nettype wire
